>>> rtl/sxs_pkg.sv
// Shared types and constants for the stream extremes and statistics block.
// Used by the tracker, the divider and the top level.
package sxs_pkg;

    localparam int MAX_ITEMS  = 64;
    localparam int CNT_W      = $clog2(MAX_ITEMS + 1);
    localparam int VAL_W      = 32;
    localparam int MEAN_W     = 42;
    localparam int MEAN_SCALE = 1000;
    // |sum| * 1000 stays below 2^41
    localparam int SCALED_W   = 41;
    // 2 * |sum| * 1000 + count
    localparam int DIVD_W     = SCALED_W + 2;
    // 2 * count
    localparam int DIVS_W     = CNT_W + 1;
    localparam int STEP_W     = $clog2(DIVD_W + 1);

    localparam int OUT_BITS   = 6 * VAL_W + 5 * CNT_W + MEAN_W;
    localparam int OUT_W      = ((OUT_BITS + 7) / 8) * 8;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCALE,
        ST_START,
        ST_DIV,
        ST_HOLD
    } t_state;

    typedef struct packed {
        logic signed [VAL_W-1:0] largest;
        logic signed [VAL_W-1:0] smallest;
        logic signed [VAL_W-1:0] ruh;
        logic [CNT_W-1:0]        ruh_count;
        logic [CNT_W-1:0]        ruh_pos;
        logic signed [VAL_W-1:0] rul;
        logic [CNT_W-1:0]        rul_count;
        logic [CNT_W-1:0]        rul_pos;
        logic signed [VAL_W-1:0] total;
        logic signed [VAL_W-1:0] multiplied;
        logic [CNT_W-1:0]        count;
    } t_stats;

endpackage

>>> rtl/stream_extremes_and_statistics_top.sv
// Top level of the stream extremes and statistics block.
// Depends on sxs_pkg, sxs_track and sxs_div.
//
// Each item carries one signed 32-bit value; tlast closes the set. An item
// without tlast leaves the block in its idle state, ready for the next item.
// An item with tlast holds off the next item while the summary is formed: the
// running state is updated, the sum is scaled by 1000, the divider is loaded,
// the bit-serial divider forms the rounded mean and the result moves into the
// output register. While the previous result still waits in the output
// register, the last step stalls until it leaves. The result then sits in the
// output register while the next set streams in. Values past the 64th of a
// set are dropped, but their tlast still closes the set.
module stream_extremes_and_statistics_top
    import sxs_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  logic [VAL_W-1:0] i_s_axis_tdata,   // value[31:0]
    input  logic             i_s_axis_tlast,   // last
    output logic             o_m_axis_tvalid,
    input  logic             i_m_axis_tready,
    // largest[31:0] smallest[63:32] runner_up_high[95:64]
    // runner_up_high_count[102:96] runner_up_high_pos[109:103]
    // runner_up_low[141:110] runner_up_low_count[148:142]
    // runner_up_low_pos[155:149] total[187:156] multiplied[219:188]
    // mean_milli[261:220] accepted_count[268:262] zeros[271:269]
    output logic [OUT_W-1:0] o_m_axis_tdata
);

    t_state r_state, n_state;
    t_stats stats;

    logic                take, in_acc, clear, start, load, out_free;
    logic [DIVD_W-1:0]   quotient;
    logic                div_done;
    logic [SCALED_W-1:0] r_scaled;
    logic                r_neg;
    logic [VAL_W-1:0]    mag;
    logic [DIVD_W-1:0]   dividend;
    logic [MEAN_W-1:0]   mean;
    logic [OUT_W-1:0]    packed_out;
    logic [OUT_W-1:0]    r_out_data;
    logic                r_out_valid;

    assign in_acc   = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free = !r_out_valid || i_m_axis_tready;

    sxs_track u_track (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (take),
        .i_value (i_s_axis_tdata),
        .i_clear (clear),
        .o_stats (stats)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (in_acc && i_s_axis_tlast) begin
                n_state = ST_SCALE;
            end
            ST_SCALE: n_state = ST_START;
            ST_START: n_state = ST_DIV;
            ST_DIV:   if (div_done) begin
                n_state = out_free ? ST_IDLE : ST_HOLD;
            end
            ST_HOLD:  if (out_free) begin
                n_state = ST_IDLE;
            end
            default:  n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_s_axis_tready = 1'b0;
        take            = 1'b0;
        start           = 1'b0;
        load            = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_s_axis_tready = 1'b1;
                take            = in_acc;
            end
            ST_SCALE: ;
            ST_START: start = 1'b1;
            ST_DIV:   load  = div_done && out_free;
            ST_HOLD:  load  = out_free;
            default:  ;
        endcase
    end

    assign clear = load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // magnitude of the wrapped sum, scaled by 1000
    assign mag = stats.total[VAL_W-1] ? (~stats.total + VAL_W'(1)) : stats.total;

    always_ff @(posedge i_clk) begin
        if (r_state == ST_SCALE) begin
            r_scaled <= SCALED_W'(mag) * SCALED_W'(MEAN_SCALE);
            r_neg    <= stats.total[VAL_W-1];
        end
    end

    // round half away from zero: (2*mag + n) / (2*n)
    assign dividend = {1'b0, r_scaled, 1'b0} + DIVD_W'(stats.count);

    sxs_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_dividend (dividend),
        .i_divisor  ({stats.count, 1'b0}),
        .o_done     (div_done),
        .o_quotient (quotient)
    );

    assign mean = r_neg ? (~quotient[MEAN_W-1:0] + MEAN_W'(1)) : quotient[MEAN_W-1:0];

    assign packed_out = {
        (OUT_W - OUT_BITS)'(0),
        stats.count,
        mean,
        stats.multiplied,
        stats.total,
        stats.rul_pos,
        stats.rul_count,
        stats.rul,
        stats.ruh_pos,
        stats.ruh_count,
        stats.ruh,
        stats.smallest,
        stats.largest
    };

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out_data <= packed_out;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

endmodule

>>> rtl/sxs_track.sv
// Running statistics of one set: extremes, second extremes, sum, product, count.
// Depends on sxs_pkg.
module sxs_track
    import sxs_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_take,
    input  logic signed [VAL_W-1:0] i_value,
    input  logic                    i_clear,
    output t_stats                  o_stats
);

    logic signed [VAL_W-1:0] r_top, n_top, r_st, n_st;
    logic signed [VAL_W-1:0] r_bot, n_bot, r_sb, n_sb;
    logic [CNT_W-1:0] r_tc, n_tc, r_tf, n_tf, r_stc, n_stc, r_stf, n_stf;
    logic [CNT_W-1:0] r_bc, n_bc, r_bf, n_bf, r_sbc, n_sbc, r_sbf, n_sbf;
    logic [VAL_W-1:0] r_sum, n_sum, r_prod, n_prod;
    logic [CNT_W-1:0] r_seen, n_seen;
    logic [CNT_W-1:0] pos;

    assign pos = r_seen + CNT_W'(1);

    always_comb begin
        n_top = r_top; n_tc = r_tc; n_tf = r_tf;
        n_st  = r_st;  n_stc = r_stc; n_stf = r_stf;
        n_bot = r_bot; n_bc = r_bc; n_bf = r_bf;
        n_sb  = r_sb;  n_sbc = r_sbc; n_sbf = r_sbf;
        n_sum = r_sum; n_prod = r_prod; n_seen = r_seen;
        if (i_clear) begin
            n_top = '0; n_tc = '0; n_tf = '0;
            n_st  = '0; n_stc = '0; n_stf = '0;
            n_bot = '0; n_bc = '0; n_bf = '0;
            n_sb  = '0; n_sbc = '0; n_sbf = '0;
            n_sum = '0; n_prod = VAL_W'(1); n_seen = '0;
        end else if (i_take && (r_seen < CNT_W'(MAX_ITEMS))) begin
            if (r_seen == '0) begin
                n_top = i_value; n_tc = CNT_W'(1); n_tf = pos;
                n_bot = i_value; n_bc = CNT_W'(1); n_bf = pos;
            end else begin
                // maximum side
                if (i_value > r_top) begin
                    n_st = r_top; n_stc = r_tc; n_stf = r_tf;
                    n_top = i_value; n_tc = CNT_W'(1); n_tf = pos;
                end else if (i_value == r_top) begin
                    n_tc = r_tc + CNT_W'(1);
                end else if ((r_stc == '0) || (i_value > r_st)) begin
                    n_st = i_value; n_stc = CNT_W'(1); n_stf = pos;
                end else if (i_value == r_st) begin
                    n_stc = r_stc + CNT_W'(1);
                end
                // minimum side
                if (i_value < r_bot) begin
                    n_sb = r_bot; n_sbc = r_bc; n_sbf = r_bf;
                    n_bot = i_value; n_bc = CNT_W'(1); n_bf = pos;
                end else if (i_value == r_bot) begin
                    n_bc = r_bc + CNT_W'(1);
                end else if ((r_sbc == '0) || (i_value < r_sb)) begin
                    n_sb = i_value; n_sbc = CNT_W'(1); n_sbf = pos;
                end else if (i_value == r_sb) begin
                    n_sbc = r_sbc + CNT_W'(1);
                end
            end
            n_sum  = r_sum + VAL_W'(i_value);
            // low half of the product is the same for signed and unsigned
            n_prod = r_prod * VAL_W'(i_value);
            n_seen = pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_top <= '0; r_tc <= '0; r_tf <= '0;
            r_st  <= '0; r_stc <= '0; r_stf <= '0;
            r_bot <= '0; r_bc <= '0; r_bf <= '0;
            r_sb  <= '0; r_sbc <= '0; r_sbf <= '0;
            r_sum <= '0; r_prod <= VAL_W'(1); r_seen <= '0;
        end else begin
            r_top <= n_top; r_tc <= n_tc; r_tf <= n_tf;
            r_st  <= n_st;  r_stc <= n_stc; r_stf <= n_stf;
            r_bot <= n_bot; r_bc <= n_bc; r_bf <= n_bf;
            r_sb  <= n_sb;  r_sbc <= n_sbc; r_sbf <= n_sbf;
            r_sum <= n_sum; r_prod <= n_prod; r_seen <= n_seen;
        end
    end

    always_comb begin
        o_stats.largest    = r_top;
        o_stats.smallest   = r_bot;
        o_stats.ruh        = (r_stc != '0) ? r_st : '0;
        o_stats.ruh_count  = r_stc;
        o_stats.ruh_pos    = (r_stc != '0) ? r_stf : '0;
        o_stats.rul        = (r_sbc != '0) ? r_sb : '0;
        o_stats.rul_count  = r_sbc;
        o_stats.rul_pos    = (r_sbc != '0) ? r_sbf : '0;
        o_stats.total      = r_sum;
        o_stats.multiplied = r_prod;
        o_stats.count      = r_seen;
    end

endmodule

>>> rtl/sxs_div.sv
// Restoring divider, one quotient bit per cycle, for the rounded mean.
// Depends on sxs_pkg.
module sxs_div
    import sxs_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DIVD_W-1:0] i_dividend,
    input  logic [DIVS_W-1:0] i_divisor,
    output logic              o_done,
    output logic [DIVD_W-1:0] o_quotient
);

    logic [DIVD_W-1:0] r_quo, n_quo;
    logic [DIVS_W-1:0] r_rem, n_rem, r_dvs;
    logic [STEP_W-1:0] r_steps, n_steps;
    logic              r_done, n_done;
    logic [DIVS_W:0]   shifted;
    logic              fits;

    assign shifted = {r_rem, r_quo[DIVD_W-1]};
    assign fits    = shifted >= {1'b0, r_dvs};

    always_comb begin
        n_quo   = r_quo;
        n_rem   = r_rem;
        n_steps = r_steps;
        n_done  = 1'b0;
        if (i_start) begin
            n_quo   = i_dividend;
            n_rem   = '0;
            n_steps = STEP_W'(DIVD_W);
        end else if (r_steps != '0) begin
            n_rem   = fits ? DIVS_W'(shifted - {1'b0, r_dvs}) : DIVS_W'(shifted);
            n_quo   = {r_quo[DIVD_W-2:0], fits};
            n_steps = r_steps - STEP_W'(1);
            n_done  = (r_steps == STEP_W'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_steps <= '0;
            r_done  <= 1'b0;
        end else begin
            r_steps <= n_steps;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_quo <= n_quo;
        r_rem <= n_rem;
        if (i_start) begin
            r_dvs <= i_divisor;
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

>>> bench/tb_stream_extremes_and_statistics_top.sv
`timescale 1ns / 1ps
// Self-checking bench for stream_extremes_and_statistics_top: streams value sets,
// predicts each set summary on its own and compares every output field.
// Depends on sxs_pkg and the RTL of the block.
module tb_stream_extremes_and_statistics_top;
    import sxs_pkg::*;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int DRAIN_CYCLES = 60;
    localparam int ITEM_TARGET  = 2000;
    localparam int QUIET_FROM   = 1700;
    localparam int PAD_W        = OUT_W - OUT_BITS;

    // Output item layout, highest field first.
    typedef struct packed {
        logic [PAD_W-1:0]         pad;
        logic [CNT_W-1:0]         count;
        logic signed [MEAN_W-1:0] mean_milli;
        logic signed [VAL_W-1:0]  multiplied;
        logic signed [VAL_W-1:0]  total;
        logic [CNT_W-1:0]         low2_pos;
        logic [CNT_W-1:0]         low2_count;
        logic signed [VAL_W-1:0]  low2;
        logic [CNT_W-1:0]         high2_pos;
        logic [CNT_W-1:0]         high2_count;
        logic signed [VAL_W-1:0]  high2;
        logic signed [VAL_W-1:0]  smallest;
        logic signed [VAL_W-1:0]  largest;
    } set_summary_t;

    class extremes_scoreboard;
        set_summary_t expected_summaries[$];
        int errors;
        logic signed [VAL_W-1:0] hi, hi2, lo, lo2;
        int hi_cnt, hi_first, hi2_cnt, hi2_first;
        int lo_cnt, lo_first, lo2_cnt, lo2_first;
        logic [VAL_W-1:0] sum, prod;
        int seen;

        function new();
            errors = 0;
            restart_set();
        endfunction

        function void restart_set();
            hi = 0; hi2 = 0; lo = 0; lo2 = 0;
            hi_cnt = 0; hi_first = 0; hi2_cnt = 0; hi2_first = 0;
            lo_cnt = 0; lo_first = 0; lo2_cnt = 0; lo2_first = 0;
            sum = 0; prod = 1; seen = 0;
        endfunction

        function longint rounded_mean_milli();
            longint scaled, mag, q;
            scaled = longint'($signed(sum)) * MEAN_SCALE;
            mag = (scaled < 0) ? -scaled : scaled;
            q = (2 * mag + seen) / (2 * seen);
            return (scaled < 0) ? -q : q;
        endfunction

        function void note_value(logic [VAL_W-1:0] raw, logic last);
            logic signed [VAL_W-1:0] v;
            int pos;
            set_summary_t s;
            v = raw;
            pos = seen + 1;
            if (seen < MAX_ITEMS) begin
                if (seen == 0) begin
                    hi = v; hi_cnt = 1; hi_first = pos;
                    lo = v; lo_cnt = 1; lo_first = pos;
                end else begin
                    // old maximum drops to second place with its count and position
                    if (v > hi) begin
                        hi2 = hi; hi2_cnt = hi_cnt; hi2_first = hi_first;
                        hi = v; hi_cnt = 1; hi_first = pos;
                    end else if (v == hi) begin
                        hi_cnt++;
                    end else if (hi2_cnt == 0 || v > hi2) begin
                        hi2 = v; hi2_cnt = 1; hi2_first = pos;
                    end else if (v == hi2) begin
                        hi2_cnt++;
                    end
                    if (v < lo) begin
                        lo2 = lo; lo2_cnt = lo_cnt; lo2_first = lo_first;
                        lo = v; lo_cnt = 1; lo_first = pos;
                    end else if (v == lo) begin
                        lo_cnt++;
                    end else if (lo2_cnt == 0 || v < lo2) begin
                        lo2 = v; lo2_cnt = 1; lo2_first = pos;
                    end else if (v == lo2) begin
                        lo2_cnt++;
                    end
                end
                sum = sum + raw;
                prod = prod * raw;
                seen = pos;
            end
            if (last) begin
                s = '0;
                s.largest     = hi;
                s.smallest    = lo;
                s.high2       = (hi2_cnt != 0) ? hi2 : '0;
                s.high2_count = CNT_W'(hi2_cnt);
                s.high2_pos   = (hi2_cnt != 0) ? CNT_W'(hi2_first) : '0;
                s.low2        = (lo2_cnt != 0) ? lo2 : '0;
                s.low2_count  = CNT_W'(lo2_cnt);
                s.low2_pos    = (lo2_cnt != 0) ? CNT_W'(lo2_first) : '0;
                s.total       = sum;
                s.multiplied  = prod;
                s.mean_milli  = MEAN_W'(rounded_mean_milli());
                s.count       = CNT_W'(seen);
                expected_summaries.push_back(s);
                restart_set();
            end
        endfunction

        task report_mismatch(string field, longint got, longint want);
            $display("[%0t] mismatch on %s: got %0d, want %0d", $time, field, got, want);
            errors++;
        endtask

        task check_summary(set_summary_t got);
            set_summary_t want;
            if (expected_summaries.size() == 0) begin
                report_mismatch("unexpected result item", 1, 0);
                return;
            end
            want = expected_summaries.pop_front();
            if (got.largest != want.largest)
                report_mismatch("largest", got.largest, want.largest);
            if (got.smallest != want.smallest)
                report_mismatch("smallest", got.smallest, want.smallest);
            if (got.high2 != want.high2)
                report_mismatch("runner_up_high", got.high2, want.high2);
            if (got.high2_count != want.high2_count)
                report_mismatch("runner_up_high_count", got.high2_count, want.high2_count);
            if (got.high2_pos != want.high2_pos)
                report_mismatch("runner_up_high_pos", got.high2_pos, want.high2_pos);
            if (got.low2 != want.low2)
                report_mismatch("runner_up_low", got.low2, want.low2);
            if (got.low2_count != want.low2_count)
                report_mismatch("runner_up_low_count", got.low2_count, want.low2_count);
            if (got.low2_pos != want.low2_pos)
                report_mismatch("runner_up_low_pos", got.low2_pos, want.low2_pos);
            if (got.total != want.total)
                report_mismatch("total", got.total, want.total);
            if (got.multiplied != want.multiplied)
                report_mismatch("multiplied", got.multiplied, want.multiplied);
            if (got.mean_milli != want.mean_milli)
                report_mismatch("mean_milli", got.mean_milli, want.mean_milli);
            if (got.count != want.count)
                report_mismatch("accepted_count", got.count, want.count);
            if (got.pad !== '0)
                report_mismatch("padding bits", got.pad, 0);
        endtask
    endclass

    logic             i_clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             s_tvalid = 1'b0;
    logic [VAL_W-1:0] s_tdata = '0;
    logic             s_tlast = 1'b0;
    logic             m_tready = 1'b0;
    logic             s_tready;
    logic             m_tvalid;
    logic [OUT_W-1:0] m_tdata;

    extremes_scoreboard sb = new();
    int  cycles = 0;
    int  items_sent = 0;
    bit  tx_idle_ok = 1'b0;
    bit  rx_idle_ok = 1'b0;
    int  rx_stall_left = 0;

    stream_extremes_and_statistics_top DUT (
        .i_clk           (i_clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tlast  (s_tlast),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Result side: check each accepted item, then pick the next tready.
    always @(posedge i_clk) begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_summary(set_summary_t'(m_tdata));
        if (rx_stall_left > 0) begin
            rx_stall_left--;
            m_tready <= 1'b0;
        end else if (rx_idle_ok && $urandom_range(0, 5) == 0) begin
            rx_stall_left = $urandom_range(1, 14) - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    task send_item(logic [VAL_W-1:0] v, logic last);
        int gap;
        if (tx_idle_ok && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 14);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= v;
        s_tlast  <= last;
        do @(posedge i_clk); while (!s_tready);
        sb.note_value(v, last);
        items_sent++;
    endtask

    task send_set(logic [VAL_W-1:0] vals[$]);
        foreach (vals[i])
            send_item(vals[i], i == vals.size() - 1);
    endtask

    function automatic logic [VAL_W-1:0] pick_value();
        case ($urandom_range(0, 7))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2, 3:    return int'($urandom_range(0, 6)) - 3;
            default: return $urandom;
        endcase
    endfunction

    initial begin
        logic [VAL_W-1:0] vals[$];
        int len;
        repeat (12) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: single item, no runner-up, extremes, ordering, repeats, wrap.
        send_set('{32'd0});
        send_set('{32'h7fff_ffff});
        send_set('{32'h8000_0000});
        send_set('{-32'sd5, -32'sd5, -32'sd5});
        send_set('{32'd1, 32'd2, 32'd3});
        send_set('{32'd3, 32'd2, 32'd1});
        send_set('{32'd5, 32'd3, 32'd3, 32'd5, 32'd1, 32'd3, 32'd1});
        send_set('{32'h7fff_ffff, 32'd1, 32'h8000_0000, 32'hffff_ffff, 32'd0});
        send_set('{32'h7fff_ffff, 32'h7fff_ffff});
        // Overflow: 64 values summing to -4 (mean lands on a half), then dropped items.
        vals.delete();
        for (int k = 0; k < MAX_ITEMS; k++)
            vals.push_back((k == 0) ? -36 : ((k % 2) ? k : -k));
        vals.push_back(32'h7fff_ffff);
        vals.push_back(32'h7fff_ffff);
        send_set(vals);

        while (items_sent < ITEM_TARGET) begin
            if (items_sent >= QUIET_FROM) begin
                tx_idle_ok <= 1'b0;
                rx_idle_ok <= 1'b0;
            end else begin
                tx_idle_ok <= ($urandom_range(0, 2) != 0);
                rx_idle_ok <= ($urandom_range(0, 2) != 0);
            end
            if ($urandom_range(0, 14) == 0)
                len = $urandom_range(60, 80);
            else
                len = $urandom_range(1, 12);
            vals.delete();
            repeat (len) vals.push_back(pick_value());
            send_set(vals);
        end
        s_tvalid <= 1'b0;

        while (sb.expected_summaries.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
